// ===== design/gcc_pkg.sv =====
`timescale 1ns / 1ps

package gcc_pkg;

    localparam int MAX_DENOMS  = 4;
    localparam int MAX_COINS   = 64;
    localparam int COIN_W      = 16;
    localparam int COUNT_W     = 3;
    localparam int SLOT_W      = $clog2(MAX_DENOMS);
    localparam int TALLY_W     = 7;
    localparam int TALLY_MAX   = (1 << TALLY_W) - 1;
    localparam int BITCNT_W    = $clog2(COIN_W);
    localparam int PC_W        = 5;
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_D = 3'd4;

    // result status codes
    localparam logic [1:0] ST_COIN       = 2'd0;
    localparam logic [1:0] ST_NONE       = 2'd1;
    localparam logic [1:0] ST_IMPOSSIBLE = 2'd2;
    localparam logic [1:0] ST_TOO_MANY   = 2'd3;

    typedef logic [3:0] t_op;
    typedef logic [3:0] t_cond;
    typedef logic [PC_W-1:0] t_pc;
    typedef logic [MAX_DENOMS-1:0][COIN_W-1:0] t_coin_arr;

    // datapath operations
    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_CX01      = 4'd1;
    localparam t_op OP_CX23      = 4'd2;
    localparam t_op OP_CX02      = 4'd3;
    localparam t_op OP_CX13      = 4'd4;
    localparam t_op OP_CX12      = 4'd5;
    localparam t_op OP_SLOT_TOP  = 4'd6;
    localparam t_op OP_DIV_LOAD  = 4'd7;
    localparam t_op OP_DIV_STEP  = 4'd8;
    localparam t_op OP_DIV_END   = 4'd9;
    localparam t_op OP_SLOT_DEC  = 4'd10;
    localparam t_op OP_EMIT_COIN = 4'd11;
    localparam t_op OP_EMIT_ZERO = 4'd12;
    localparam t_op OP_EMIT_IMP  = 4'd13;
    localparam t_op OP_EMIT_TM   = 4'd14;

    // jump conditions
    localparam t_cond C_NEVER      = 4'd0;
    localparam t_cond C_ALWAYS     = 4'd1;
    localparam t_cond C_NOSTART    = 4'd2;
    localparam t_cond C_REM_ZERO   = 4'd3;
    localparam t_cond C_REM_NZ     = 4'd4;
    localparam t_cond C_COIN_ZERO  = 4'd5;
    localparam t_cond C_DIV_MORE   = 4'd6;
    localparam t_cond C_SLOT_NZ    = 4'd7;
    localparam t_cond C_TOO_MANY   = 4'd8;
    localparam t_cond C_TALLY_ZERO = 4'd9;
    localparam t_cond C_SLOT_MORE  = 4'd10;
    localparam t_cond C_EMIT_DONE  = 4'd11;

    // program addresses
    localparam t_pc PC_IDLE     = 5'd0;
    localparam t_pc PC_ZCHK     = 5'd1;
    localparam t_pc PC_SORT0    = 5'd2;
    localparam t_pc PC_SORT1    = 5'd3;
    localparam t_pc PC_SORT2    = 5'd4;
    localparam t_pc PC_SORT3    = 5'd5;
    localparam t_pc PC_SORT4    = 5'd6;
    localparam t_pc PC_GTOP     = 5'd7;
    localparam t_pc PC_DINIT    = 5'd8;
    localparam t_pc PC_DSTEP    = 5'd9;
    localparam t_pc PC_DEND     = 5'd10;
    localparam t_pc PC_GNEXT    = 5'd11;
    localparam t_pc PC_RCHK     = 5'd12;
    localparam t_pc PC_ETOP     = 5'd13;
    localparam t_pc PC_ECHK     = 5'd14;
    localparam t_pc PC_ECOIN    = 5'd15;
    localparam t_pc PC_EDONE    = 5'd16;
    localparam t_pc PC_ENEXT    = 5'd17;
    localparam t_pc PC_OUT_ZERO = 5'd18;
    localparam t_pc PC_OUT_IMP  = 5'd19;
    localparam t_pc PC_OUT_TM   = 5'd20;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic rem_zero;
        logic coin_zero;
        logic div_more;
        logic slot_nz;
        logic too_many;
        logic tally_zero;
        logic slot_more;
        logic emit_done;
    } t_dp_flags;

    function automatic t_uword uw(t_op op, t_cond cond, t_pc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: one word per step, fall through to pc+1 when the jump is not taken
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:     w = uw(OP_NOP,       C_NOSTART,    PC_IDLE);
            PC_ZCHK:     w = uw(OP_NOP,       C_REM_ZERO,   PC_OUT_ZERO);
            PC_SORT0:    w = uw(OP_CX01,      C_NEVER,      PC_IDLE);
            PC_SORT1:    w = uw(OP_CX23,      C_NEVER,      PC_IDLE);
            PC_SORT2:    w = uw(OP_CX02,      C_NEVER,      PC_IDLE);
            PC_SORT3:    w = uw(OP_CX13,      C_NEVER,      PC_IDLE);
            PC_SORT4:    w = uw(OP_CX12,      C_NEVER,      PC_IDLE);
            PC_GTOP:     w = uw(OP_SLOT_TOP,  C_NEVER,      PC_IDLE);
            PC_DINIT:    w = uw(OP_DIV_LOAD,  C_COIN_ZERO,  PC_GNEXT);
            PC_DSTEP:    w = uw(OP_DIV_STEP,  C_DIV_MORE,   PC_DSTEP);
            PC_DEND:     w = uw(OP_DIV_END,   C_NEVER,      PC_IDLE);
            PC_GNEXT:    w = uw(OP_SLOT_DEC,  C_SLOT_NZ,    PC_DINIT);
            PC_RCHK:     w = uw(OP_NOP,       C_REM_NZ,     PC_OUT_IMP);
            PC_ETOP:     w = uw(OP_SLOT_TOP,  C_TOO_MANY,   PC_OUT_TM);
            PC_ECHK:     w = uw(OP_NOP,       C_TALLY_ZERO, PC_ENEXT);
            PC_ECOIN:    w = uw(OP_EMIT_COIN, C_SLOT_MORE,  PC_ECOIN);
            PC_EDONE:    w = uw(OP_NOP,       C_EMIT_DONE,  PC_IDLE);
            PC_ENEXT:    w = uw(OP_SLOT_DEC,  C_ALWAYS,     PC_ECHK);
            PC_OUT_ZERO: w = uw(OP_EMIT_ZERO, C_ALWAYS,     PC_IDLE);
            PC_OUT_IMP:  w = uw(OP_EMIT_IMP,  C_ALWAYS,     PC_IDLE);
            PC_OUT_TM:   w = uw(OP_EMIT_TM,   C_ALWAYS,     PC_IDLE);
            default:     w = uw(OP_NOP,       C_ALWAYS,     PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== design/gcc_sequencer.sv =====
`timescale 1ns / 1ps

module gcc_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gcc_pkg::t_dp_flags  i_flags,
    output gcc_pkg::t_op        o_op,
    output logic                o_busy
);
    import gcc_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_jump;

    assign w_word = ucode(r_pc);
    assign o_op   = w_word.op;
    assign o_busy = (r_pc != PC_IDLE);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:      w_jump = 1'b0;
            C_ALWAYS:     w_jump = 1'b1;
            C_NOSTART:    w_jump = !i_start;
            C_REM_ZERO:   w_jump = i_flags.rem_zero;
            C_REM_NZ:     w_jump = !i_flags.rem_zero;
            C_COIN_ZERO:  w_jump = i_flags.coin_zero;
            C_DIV_MORE:   w_jump = i_flags.div_more;
            C_SLOT_NZ:    w_jump = i_flags.slot_nz;
            C_TOO_MANY:   w_jump = i_flags.too_many;
            C_TALLY_ZERO: w_jump = i_flags.tally_zero;
            C_SLOT_MORE:  w_jump = i_flags.slot_more;
            C_EMIT_DONE:  w_jump = i_flags.emit_done;
            default:      w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_word.target : PC_W'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== design/gcc_datapath.sv =====
`timescale 1ns / 1ps

module gcc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gcc_pkg::t_op              i_op,
    input  logic                      i_load,
    input  logic [gcc_pkg::COIN_W-1:0] i_amount,
    input  gcc_pkg::t_coin_arr        i_coins,
    output gcc_pkg::t_dp_flags        o_flags,
    output logic                      o_valid,
    output logic [gcc_pkg::COIN_W-1:0] o_coin_value,
    output logic [1:0]                o_status,
    output logic                      o_last
);
    import gcc_pkg::*;

    logic [COIN_W-1:0]   r_sorted [MAX_DENOMS];
    logic [TALLY_W-1:0]  r_tally  [MAX_DENOMS];
    logic [COIN_W-1:0]   r_rem;
    logic [TALLY_W-1:0]  r_total;
    logic [SLOT_W-1:0]   r_slot;
    logic [BITCNT_W-1:0] r_bitcnt;
    logic [COIN_W-1:0]   r_div_p;
    logic [COIN_W-1:0]   r_div_q;
    logic [COIN_W-1:0]   r_divisor;
    logic                r_out_valid;
    logic [COIN_W-1:0]   r_out_coin;
    logic [1:0]          r_out_status;
    logic                r_out_last;

    logic [COIN_W-1:0]   w_cur_coin;
    logic [TALLY_W-1:0]  w_cur_tally;
    logic [COIN_W:0]     w_shift;
    logic                w_ge;
    logic [COIN_W:0]     w_diff;
    logic [COIN_W:0]     w_sum;
    logic [TALLY_W-1:0]  w_q_sat;
    logic [TALLY_W-1:0]  w_total_sat;

    assign w_cur_coin  = r_sorted[r_slot];
    assign w_cur_tally = r_tally[r_slot];

    // one restoring divide step
    assign w_shift = {r_div_p, r_div_q[COIN_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});
    assign w_diff  = w_shift - {1'b0, r_divisor};

    assign w_sum       = (COIN_W+1)'(r_total) + (COIN_W+1)'(r_div_q);
    assign w_q_sat     = (r_div_q > COIN_W'(TALLY_MAX)) ? TALLY_W'(TALLY_MAX)
                                                        : r_div_q[TALLY_W-1:0];
    assign w_total_sat = (w_sum > (COIN_W+1)'(TALLY_MAX)) ? TALLY_W'(TALLY_MAX)
                                                          : w_sum[TALLY_W-1:0];

    always_comb begin
        o_flags.rem_zero   = (r_rem == '0);
        o_flags.coin_zero  = (w_cur_coin == '0);
        o_flags.div_more   = (r_bitcnt != BITCNT_W'(COIN_W - 1));
        o_flags.slot_nz    = (r_slot != '0);
        o_flags.too_many   = (r_total > TALLY_W'(MAX_COINS));
        o_flags.tally_zero = (w_cur_tally == '0);
        o_flags.slot_more  = (w_cur_tally > TALLY_W'(1));
        o_flags.emit_done  = (r_total == '0);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_bitcnt    <= '0;
        end else begin
            r_out_valid <= (i_op == OP_EMIT_COIN) || (i_op == OP_EMIT_ZERO) ||
                           (i_op == OP_EMIT_IMP)  || (i_op == OP_EMIT_TM);
            case (i_op)
                OP_SLOT_TOP:  r_slot   <= SLOT_W'(MAX_DENOMS - 1);
                OP_SLOT_DEC:  r_slot   <= SLOT_W'(r_slot - 1'b1);
                OP_DIV_LOAD:  r_bitcnt <= '0;
                OP_DIV_STEP:  r_bitcnt <= BITCNT_W'(r_bitcnt + 1'b1);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < MAX_DENOMS; i++) begin
                r_sorted[i] <= i_coins[i];
                r_tally[i]  <= '0;
            end
            r_rem   <= i_amount;
            r_total <= '0;
        end else begin
            case (i_op)
                OP_CX01: if (r_sorted[1] < r_sorted[0]) begin
                    r_sorted[0] <= r_sorted[1];
                    r_sorted[1] <= r_sorted[0];
                end
                OP_CX23: if (r_sorted[3] < r_sorted[2]) begin
                    r_sorted[2] <= r_sorted[3];
                    r_sorted[3] <= r_sorted[2];
                end
                OP_CX02: if (r_sorted[2] < r_sorted[0]) begin
                    r_sorted[0] <= r_sorted[2];
                    r_sorted[2] <= r_sorted[0];
                end
                OP_CX13: if (r_sorted[3] < r_sorted[1]) begin
                    r_sorted[1] <= r_sorted[3];
                    r_sorted[3] <= r_sorted[1];
                end
                OP_CX12: if (r_sorted[2] < r_sorted[1]) begin
                    r_sorted[1] <= r_sorted[2];
                    r_sorted[2] <= r_sorted[1];
                end
                OP_DIV_LOAD: begin
                    r_div_p   <= '0;
                    r_div_q   <= r_rem;
                    r_divisor <= w_cur_coin;
                end
                OP_DIV_STEP: begin
                    r_div_p <= w_ge ? w_diff[COIN_W-1:0] : w_shift[COIN_W-1:0];
                    r_div_q <= {r_div_q[COIN_W-2:0], w_ge};
                end
                OP_DIV_END: begin
                    r_rem           <= r_div_p;
                    r_tally[r_slot] <= w_q_sat;
                    r_total         <= w_total_sat;
                end
                OP_EMIT_COIN: begin
                    r_tally[r_slot] <= TALLY_W'(w_cur_tally - 1'b1);
                    r_total         <= TALLY_W'(r_total - 1'b1);
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_EMIT_COIN: begin
                r_out_coin   <= w_cur_coin;
                r_out_status <= ST_COIN;
                r_out_last   <= (r_total == TALLY_W'(1));
            end
            OP_EMIT_ZERO: begin
                r_out_coin   <= '0;
                r_out_status <= ST_NONE;
                r_out_last   <= 1'b1;
            end
            OP_EMIT_IMP: begin
                r_out_coin   <= '0;
                r_out_status <= ST_IMPOSSIBLE;
                r_out_last   <= 1'b1;
            end
            OP_EMIT_TM: begin
                r_out_coin   <= '0;
                r_out_status <= ST_TOO_MANY;
                r_out_last   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_coin_value = r_out_coin;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

endmodule

// ===== design/greedy_coin_change_core.sv =====
`timescale 1ns / 1ps

// Greedy coin change core.
// Pulse start with an amount on i_amount while busy is low; the transfer
// happens on that edge and busy is high from the following cycle. The block
// sorts the active denominations, splits the amount largest coin first, and
// then emits one result per coin on o_coin_value / o_status / o_last, each
// marked by a one-cycle o_valid strobe; o_last flags the final result.
// A zero amount, an uncoverable remainder or more than the coin limit
// each give one result with the matching status and o_last set.
// The zero check and the sort come first; each nonzero slot then runs the
// 16-step bit-serial divider (an empty slot is passed over), and the
// remainder, the coin limit and the top tally are checked before the first
// coin is on the ports; a zero amount is answered right after the zero check.
// Coins of one denomination follow one per cycle; moving on to the next
// passes the done check, slot step and tally check. A new amount is taken
// only when busy is low again after the final result. The receiver cannot stall.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) must be made while
// busy is low. Synchronous reset returns the sequencer to idle and the
// registers to count 3 and coins 10, 6, 1, 1.
module greedy_coin_change_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gcc_pkg::COIN_W-1:0]    i_amount,
    output logic                          o_valid,
    output logic [gcc_pkg::COIN_W-1:0]    o_coin_value,
    output logic [1:0]                    o_status,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [gcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcc_pkg::COIN_W-1:0]    i_cfg_data
);
    import gcc_pkg::*;

    logic [COUNT_W-1:0] r_coin_count;
    logic [COIN_W-1:0]  r_coin_reg [MAX_DENOMS];
    logic [COUNT_W-1:0] w_active;
    t_coin_arr          w_coins;
    t_op                w_op;
    t_dp_flags          w_flags;
    logic               w_accept;

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_count  <= COUNT_W'(3);
            r_coin_reg[0] <= COIN_W'(10);
            r_coin_reg[1] <= COIN_W'(6);
            r_coin_reg[2] <= COIN_W'(1);
            r_coin_reg[3] <= COIN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COUNT:  r_coin_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_COIN_A: r_coin_reg[0] <= i_cfg_data;
                CFG_COIN_B: r_coin_reg[1] <= i_cfg_data;
                CFG_COIN_C: r_coin_reg[2] <= i_cfg_data;
                CFG_COIN_D: r_coin_reg[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the count into 1..MAX_DENOMS, zero the unused slots
    always_comb begin
        if (r_coin_count == '0) begin
            w_active = COUNT_W'(1);
        end else if (r_coin_count > COUNT_W'(MAX_DENOMS)) begin
            w_active = COUNT_W'(MAX_DENOMS);
        end else begin
            w_active = r_coin_count;
        end
        for (int i = 0; i < MAX_DENOMS; i++) begin
            w_coins[i] = (COUNT_W'(i) < w_active) ? r_coin_reg[i] : '0;
        end
    end

    gcc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (w_flags),
        .o_op    (w_op),
        .o_busy  (busy)
    );

    gcc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_load       (w_accept),
        .i_amount     (i_amount),
        .i_coins      (w_coins),
        .o_flags      (w_flags),
        .o_valid      (o_valid),
        .o_coin_value (o_coin_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy did not rise after a transfer");

    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_COIN)) |-> (o_last && (o_coin_value == '0)))
        else $error("special result without last or with a coin value");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after the final one");

    a_coin_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_COIN)) |-> (o_coin_value != '0))
        else $error("zero denomination emitted as a coin");
`endif

endmodule
